>>> src/rrwl_pkg.sv
// Shared types, codes and widths for the recursive reader/writer lock manager.
package rrwl_pkg;

    localparam int ACTION_W      = 3;
    localparam int REQ_W         = 4;
    localparam int STATUS_W      = 3;
    localparam int COUNT_OUT_W   = 5;
    localparam int IN_DATA_W     = 8;
    localparam int OUT_DATA_W    = 16;

    localparam int DEF_REQUESTERS = 16;
    localparam int DEF_MAX_DEPTH  = 255;

    localparam logic [ACTION_W-1:0] ACT_LOCK          = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_TRY_LOCK      = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_LOCK_SHARED   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_UNLOCK        = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_UNLOCK_SHARED = 3'd4;

    localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_WAIT     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ERROR    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]    requester;
        logic [ACTION_W-1:0] action;
    } t_req;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] reader_count;
        logic                   writer_held;
        logic [STATUS_W-1:0]    status;
    } t_resp;

    typedef struct packed {
        logic writer_valid;
        logic writer_pending;
        logic depth_zero;
        logic readers_zero;
    } t_lock_view;

endpackage

>>> src/recursive_rw_lock_manager.sv
// Top level of the recursive reader/writer lock manager (writer preferred).
//
// One request beat is taken every cycle while the result side keeps up; each
// request gives exactly one result beat, which passes first through the input
// register, where the lock state is read and updated, and then through the
// result register. The single pass through the decision logic between those
// two registers sets that rate. Read depths and waiting-writer bits sit in
// flip-flops cleared by reset, so the block is ready in the cycle after reset
// is released.
module recursive_rw_lock_manager #(
    parameter int REQUESTERS = rrwl_pkg::DEF_REQUESTERS,
    parameter int MAX_DEPTH  = rrwl_pkg::DEF_MAX_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [2:0] action, [6:3] requester, [7] zero
    input  logic [rrwl_pkg::IN_DATA_W-1:0]    i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [2:0] status, [3] writer_held, [8:4] reader_count, [15:9] zero
    output logic [rrwl_pkg::OUT_DATA_W-1:0]   o_m_tdata
);
    import rrwl_pkg::*;

    logic       stage_valid;
    t_req       stage_req;
    logic       advance;
    logic       fire;
    t_resp      resp;
    t_lock_view view;

    logic  r_out_valid;
    t_resp r_out;

    assign advance = !r_out_valid || i_m_tready;
    assign fire    = stage_valid && advance;

    rrwl_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_data    (i_s_tdata),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_req     (stage_req)
    );

    rrwl_core #(
        .REQUESTERS (REQUESTERS),
        .MAX_DEPTH  (MAX_DEPTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (stage_req),
        .o_resp  (resp),
        .o_view  (view)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= stage_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= resp;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_DATA_W - $bits(t_resp))'(0), r_out};

    a_pending_needs_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        view.writer_pending |-> view.writer_valid)
        else $error("pending writer without a claimed slot");

    a_free_slot_no_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !view.writer_valid |-> view.depth_zero)
        else $error("write depth left over on a free slot");

    a_owned_slot_has_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (view.writer_valid && !view.writer_pending) |-> !view.depth_zero)
        else $error("acquired writer with zero depth");

    a_reject_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (resp.status == ST_ERROR || resp.status == ST_OVERFLOW))
        |=> $stable(view))
        else $error("error or overflow changed the lock state");

endmodule

>>> src/rrwl_in_stage.sv
// Input register stage: captures one request beat and holds it for the lock core.
module rrwl_in_stage (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [rrwl_pkg::IN_DATA_W-1:0]    i_data,
    input  logic                              i_advance,
    output logic                              o_valid,
    output rrwl_pkg::t_req                    o_req
);
    import rrwl_pkg::*;

    logic r_valid;
    t_req r_req;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= t_req'(i_data[ACTION_W+REQ_W-1:0]);
        end
    end

endmodule

>>> src/rrwl_core.sv
// Lock state registers and the single-pass decision logic for one request.
module rrwl_core #(
    parameter int REQUESTERS = rrwl_pkg::DEF_REQUESTERS,
    parameter int MAX_DEPTH  = rrwl_pkg::DEF_MAX_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  rrwl_pkg::t_req       i_req,
    output rrwl_pkg::t_resp      o_resp,
    output rrwl_pkg::t_lock_view o_view
);
    import rrwl_pkg::*;

    localparam int SLOTS   = (REQUESTERS < (1 << REQ_W)) ? REQUESTERS : (1 << REQ_W);
    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(REQUESTERS + 1);
    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

    logic               r_wv;
    logic [REQ_W-1:0]   r_wo;
    logic               r_wp;
    logic [DEPTH_W-1:0] r_wd;
    logic [DEPTH_W-1:0] r_rd [SLOTS];
    logic               r_wait [SLOTS];
    logic [CNT_W-1:0]   r_wc;
    logic [CNT_W-1:0]   r_ar;

    logic               n_wv;
    logic [REQ_W-1:0]   n_wo;
    logic               n_wp;
    logic [DEPTH_W-1:0] n_wd;
    logic [DEPTH_W-1:0] n_rd;
    logic               n_wait;
    logic [CNT_W-1:0]   n_wc;
    logic [CNT_W-1:0]   n_ar;
    logic [STATUS_W-1:0] status;

    logic [IDX_W-1:0]   idx;
    logic               req_ok;
    logic               owner;
    logic [DEPTH_W-1:0] rd;
    logic               wb;
    logic               wd_max;
    logic               rd_max;

    assign idx    = IDX_W'(i_req.requester);
    assign req_ok = 32'(i_req.requester) < REQUESTERS;
    assign owner  = r_wv && (r_wo == i_req.requester);
    assign rd     = r_rd[idx];
    assign wb     = r_wait[idx];
    assign wd_max = r_wd >= DEPTH_W'(MAX_DEPTH);
    assign rd_max = rd >= DEPTH_W'(MAX_DEPTH);

    always_comb begin
        n_wv   = r_wv;
        n_wo   = r_wo;
        n_wp   = r_wp;
        n_wd   = r_wd;
        n_rd   = rd;
        n_wait = wb;
        n_wc   = r_wc;
        n_ar   = r_ar;
        status = ST_ERROR;
        if (req_ok) begin
            unique case (i_req.action)
                ACT_LOCK, ACT_TRY_LOCK: begin
                    if (owner) begin
                        if (r_wp) begin
                            if (r_ar == '0) begin
                                n_wp   = 1'b0;
                                n_wd   = DEPTH_W'(1);
                                if (wb) begin
                                    n_wait = 1'b0;
                                    n_wc   = r_wc - CNT_W'(1);
                                end
                                status = ST_GRANTED;
                            end else begin
                                status = (i_req.action == ACT_LOCK) ? ST_WAIT : ST_REFUSED;
                            end
                        end else if (wd_max) begin
                            status = ST_OVERFLOW;
                        end else begin
                            n_wd   = r_wd + DEPTH_W'(1);
                            status = ST_GRANTED;
                        end
                    end else if (rd != '0) begin
                        status = ST_ERROR;
                    end else if (i_req.action == ACT_LOCK) begin
                        if (!wb) begin
                            n_wait = 1'b1;
                            n_wc   = r_wc + CNT_W'(1);
                        end
                        status = ST_WAIT;
                        if (!r_wv) begin
                            n_wv = 1'b1;
                            n_wo = i_req.requester;
                            if (r_ar == '0) begin
                                n_wp   = 1'b0;
                                n_wd   = DEPTH_W'(1);
                                n_wait = 1'b0;
                                n_wc   = wb ? (r_wc - CNT_W'(1)) : r_wc;
                                status = ST_GRANTED;
                            end else begin
                                n_wp = 1'b1;
                                n_wd = '0;
                            end
                        end
                    end else if (!r_wv && r_ar == '0) begin
                        n_wv   = 1'b1;
                        n_wo   = i_req.requester;
                        n_wp   = 1'b0;
                        n_wd   = DEPTH_W'(1);
                        if (wb) begin
                            n_wait = 1'b0;
                            n_wc   = r_wc - CNT_W'(1);
                        end
                        status = ST_GRANTED;
                    end else begin
                        status = ST_REFUSED;
                    end
                end
                ACT_LOCK_SHARED: begin
                    if (owner) begin
                        if (r_wp) begin
                            status = ST_ERROR;
                        end else if (wd_max) begin
                            status = ST_OVERFLOW;
                        end else begin
                            n_wd   = r_wd + DEPTH_W'(1);
                            status = ST_GRANTED;
                        end
                    end else if (rd != '0) begin
                        if (rd_max) begin
                            status = ST_OVERFLOW;
                        end else begin
                            n_rd   = rd + DEPTH_W'(1);
                            status = ST_GRANTED;
                        end
                    end else if (r_wc != '0 || r_wv) begin
                        status = ST_WAIT;
                    end else begin
                        n_rd   = DEPTH_W'(1);
                        n_ar   = r_ar + CNT_W'(1);
                        status = ST_GRANTED;
                    end
                end
                ACT_UNLOCK, ACT_UNLOCK_SHARED: begin
                    if (owner && !r_wp) begin
                        if (r_wd > DEPTH_W'(1)) begin
                            n_wd = r_wd - DEPTH_W'(1);
                        end else begin
                            n_wv = 1'b0;
                            n_wp = 1'b0;
                            n_wd = '0;
                            n_wo = '0;
                        end
                        status = ST_GRANTED;
                    end else if (i_req.action == ACT_UNLOCK_SHARED && !owner && rd != '0) begin
                        n_rd = rd - DEPTH_W'(1);
                        if (rd == DEPTH_W'(1) && r_ar != '0) begin
                            n_ar = r_ar - CNT_W'(1);
                        end
                        status = ST_GRANTED;
                    end
                end
                default: begin
                    status = ST_ERROR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv <= 1'b0;
            r_wo <= '0;
            r_wp <= 1'b0;
            r_wd <= '0;
            r_wc <= '0;
            r_ar <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_rd[i]   <= '0;
                r_wait[i] <= 1'b0;
            end
        end else if (i_fire) begin
            r_wv <= n_wv;
            r_wo <= n_wo;
            r_wp <= n_wp;
            r_wd <= n_wd;
            r_wc <= n_wc;
            r_ar <= n_ar;
            if (req_ok) begin
                r_rd[idx]   <= n_rd;
                r_wait[idx] <= n_wait;
            end
        end
    end

    assign o_resp.status       = status;
    assign o_resp.writer_held  = n_wv;
    assign o_resp.reader_count = COUNT_OUT_W'(n_ar);

    assign o_view.writer_valid   = r_wv;
    assign o_view.writer_pending = r_wp;
    assign o_view.depth_zero     = (r_wd == '0);
    assign o_view.readers_zero   = (r_ar == '0);

endmodule

>>> tb/sv/lock_table_pkg.sv
// Lock-state predictor and result scoreboard for the recursive reader/writer lock manager.
package lock_table_pkg;

    import rrwl_pkg::*;

    localparam int REQUESTERS = DEF_REQUESTERS;
    localparam int MAX_DEPTH  = DEF_MAX_DEPTH;

    class lock_table;

        bit                    held;
        logic [REQ_W-1:0]      holder;
        bit                    pending;
        int unsigned           wdepth;
        int unsigned           rdepth [REQUESTERS];
        bit                    waiting [REQUESTERS];
        int unsigned           n_waiting;
        int unsigned           readers;
        t_resp                 due_results [$];
        int                    fails;

        function void claim(logic [REQ_W-1:0] who);
            held    = 1'b1;
            holder  = who;
            pending = 1'b0;
            wdepth  = 1;
            if (waiting[who]) begin
                waiting[who] = 1'b0;
                if (n_waiting > 0) n_waiting--;
            end
        endfunction

        function logic [STATUS_W-1:0] deepen();
            if (wdepth >= MAX_DEPTH) return ST_OVERFLOW;
            wdepth++;
            return ST_GRANTED;
        endfunction

        function void release_once();
            if (wdepth > 1) begin
                wdepth--;
            end else begin
                held    = 1'b0;
                pending = 1'b0;
                wdepth  = 0;
                holder  = '0;
            end
        endfunction

        function void note_request(logic [ACTION_W-1:0] act, logic [REQ_W-1:0] who);
            t_resp               res;
            bit                  owner;
            logic [STATUS_W-1:0] st;
            st = ST_ERROR;
            if (who < REQUESTERS && act <= ACT_UNLOCK_SHARED) begin
                owner = held && holder == who;
                case (act)
                    ACT_LOCK: begin
                        if (owner) begin
                            if (pending) begin
                                if (readers == 0) begin
                                    claim(who);
                                    st = ST_GRANTED;
                                end else begin
                                    st = ST_WAIT;
                                end
                            end else begin
                                st = deepen();
                            end
                        end else if (rdepth[who] != 0) begin
                            st = ST_ERROR;
                        end else begin
                            if (!waiting[who]) begin
                                waiting[who] = 1'b1;
                                n_waiting++;
                            end
                            if (!held) begin
                                if (readers == 0) begin
                                    claim(who);
                                    st = ST_GRANTED;
                                end else begin
                                    held    = 1'b1;
                                    holder  = who;
                                    pending = 1'b1;
                                    wdepth  = 0;
                                    st      = ST_WAIT;
                                end
                            end else begin
                                st = ST_WAIT;
                            end
                        end
                    end
                    ACT_TRY_LOCK: begin
                        if (owner) begin
                            if (pending) begin
                                if (readers == 0) begin
                                    claim(who);
                                    st = ST_GRANTED;
                                end else begin
                                    st = ST_REFUSED;
                                end
                            end else begin
                                st = deepen();
                            end
                        end else if (rdepth[who] != 0) begin
                            st = ST_ERROR;
                        end else if (!held && readers == 0) begin
                            claim(who);
                            st = ST_GRANTED;
                        end else begin
                            st = ST_REFUSED;
                        end
                    end
                    ACT_LOCK_SHARED: begin
                        if (owner) begin
                            st = pending ? ST_ERROR : deepen();
                        end else if (rdepth[who] != 0) begin
                            if (rdepth[who] >= MAX_DEPTH) begin
                                st = ST_OVERFLOW;
                            end else begin
                                rdepth[who]++;
                                st = ST_GRANTED;
                            end
                        end else if (n_waiting != 0 || held) begin
                            st = ST_WAIT;
                        end else begin
                            rdepth[who] = 1;
                            readers++;
                            st = ST_GRANTED;
                        end
                    end
                    ACT_UNLOCK: begin
                        if (owner && !pending) begin
                            release_once();
                            st = ST_GRANTED;
                        end
                    end
                    default: begin
                        if (owner) begin
                            if (!pending) begin
                                release_once();
                                st = ST_GRANTED;
                            end
                        end else if (rdepth[who] != 0) begin
                            rdepth[who]--;
                            if (rdepth[who] == 0 && readers > 0) readers--;
                            st = ST_GRANTED;
                        end
                    end
                endcase
            end
            res.status       = st;
            res.writer_held  = held;
            res.reader_count = readers[COUNT_OUT_W-1:0];
            due_results.push_back(res);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] beat);
            t_resp exp_res;
            t_resp got;
            got = t_resp'(beat[$bits(t_resp)-1:0]);
            if (due_results.size() == 0) begin
                $error("result beat 0x%0h with no request outstanding", beat);
                fails++;
                return;
            end
            exp_res = due_results.pop_front();
            if (got.status !== exp_res.status) begin
                $error("status: expected %0d, got %0d", exp_res.status, got.status);
                fails++;
            end
            if (got.writer_held !== exp_res.writer_held) begin
                $error("writer_held: expected %0d, got %0d",
                       exp_res.writer_held, got.writer_held);
                fails++;
            end
            if (got.reader_count !== exp_res.reader_count) begin
                $error("reader_count: expected %0d, got %0d",
                       exp_res.reader_count, got.reader_count);
                fails++;
            end
        endfunction

    endclass

endpackage

>>> tb/sv/tb.sv
// Top-level testbench for the recursive reader/writer lock manager.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rrwl_pkg::*;
    import lock_table_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    bit                    calm_src  = 1'b0;
    bit                    calm_sink = 1'b0;
    int                    idle_cycles = 0;

    lock_table             locks;

    recursive_rw_lock_manager i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int roll;
        if (calm_src) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    task automatic send(input logic [ACTION_W-1:0] act, input logic [REQ_W-1:0] who);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, who, act};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        locks.note_request(act, who);
    endtask

    task automatic release_all();
        for (int r = 0; r < REQUESTERS; r++) begin
            while (locks.rdepth[r] != 0) send(ACT_UNLOCK_SHARED, r[REQ_W-1:0]);
        end
        if (locks.held && locks.pending) send(ACT_LOCK, locks.holder);
        while (locks.held) send(ACT_UNLOCK, locks.holder);
        for (int r = 0; r < REQUESTERS; r++) begin
            if (locks.waiting[r]) begin
                send(ACT_LOCK, r[REQ_W-1:0]);
                send(ACT_UNLOCK, r[REQ_W-1:0]);
            end
        end
    endtask

    task automatic random_burst(input int count);
        int                  roll;
        logic [ACTION_W-1:0] act;
        logic [REQ_W-1:0]    who;
        calm_src = ($urandom_range(0, 3) == 0);
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 22) act = ACT_LOCK;
            else if (roll < 32) act = ACT_TRY_LOCK;
            else if (roll < 57) act = ACT_LOCK_SHARED;
            else if (roll < 70) act = ACT_UNLOCK;
            else if (roll < 95) act = ACT_UNLOCK_SHARED;
            else act = ACTION_W'($urandom_range(ACT_UNLOCK_SHARED + 1, 7));
            if ($urandom_range(0, 4) != 0) who = REQ_W'($urandom_range(0, 3));
            else who = REQ_W'($urandom_range(0, REQUESTERS - 1));
            send(act, who);
        end
        release_all();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) locks.check_result(m_tdata);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 99) == 0) calm_sink = ~calm_sink;
            if (!calm_sink && $urandom_range(0, 39) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(5, 30)) @(posedge i_clk);
            end else begin
                m_tready <= calm_sink || ($urandom_range(0, 3) != 0);
                @(posedge i_clk);
            end
        end
    end

    initial begin
        locks = new;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send(ACT_LOCK_SHARED, 4'd1);
        send(ACT_LOCK_SHARED, 4'd1);
        send(ACT_LOCK, 4'd1);
        send(ACT_TRY_LOCK, 4'd1);
        send(ACT_LOCK, 4'd2);
        send(ACT_LOCK_SHARED, 4'd3);
        send(ACT_LOCK_SHARED, 4'd2);
        send(ACT_UNLOCK, 4'd2);
        send(ACT_UNLOCK_SHARED, 4'd2);
        send(ACT_TRY_LOCK, 4'd2);
        send(ACT_LOCK, 4'd2);
        send(ACT_UNLOCK_SHARED, 4'd1);
        send(ACT_UNLOCK_SHARED, 4'd1);
        send(ACT_TRY_LOCK, 4'd2);
        send(ACT_LOCK, 4'd2);
        send(ACT_LOCK_SHARED, 4'd2);
        send(ACT_UNLOCK, 4'd5);
        send(ACT_UNLOCK_SHARED, 4'd5);
        send(3'd5, 4'd15);
        send(3'd6, 4'd0);
        send(3'd7, 4'd15);
        send(ACT_UNLOCK_SHARED, 4'd2);
        send(ACT_UNLOCK, 4'd2);
        send(ACT_UNLOCK, 4'd2);
        send(ACT_TRY_LOCK, 4'd15);
        send(ACT_UNLOCK, 4'd15);
        release_all();

        repeat (MAX_DEPTH + 1) send(ACT_LOCK, 4'd9);
        send(ACT_LOCK_SHARED, 4'd9);
        send(ACT_TRY_LOCK, 4'd9);
        release_all();
        repeat (MAX_DEPTH + 1) send(ACT_LOCK_SHARED, 4'd6);
        release_all();

        repeat (8) random_burst($urandom_range(50, 75));

        s_tvalid <= 1'b0;
        while (locks.due_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (locks.fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> recursive_rw_lock_manager.f
src/rrwl_pkg.sv
src/rrwl_in_stage.sv
src/rrwl_core.sv
src/recursive_rw_lock_manager.sv
tb/sv/lock_table_pkg.sv
tb/sv/tb.sv
